// ===== src/ptst_pkg.sv =====
`default_nettype none

package ptst_pkg;

    // fixed field widths of the stream items
    localparam int IN_WIDTH        = 18;
    localparam int OUT_WIDTH       = 18;
    localparam int GAIN_WIDTH      = 8;
    localparam int STEP_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // worst-case width of measured angle plus or minus gain times offset
    localparam int TARGET_WIDTH    = 28;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TRACK_GAIN    = 2'd0,
        CFG_TRACK_STEP    = 2'd1,
        CFG_RECOVERY_STEP = 2'd2
    } cfg_index_t;

    // live configuration seen by both lanes
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] gain;
        logic [STEP_WIDTH-1:0] track_step;
        logic [STEP_WIDTH-1:0] recovery_step;
    } cfg_t;

    // pipeline control shared by the lanes and the merge stage
    typedef struct packed {
        logic load;
        logic advance;
        logic seen_in;
        logic seen_s1;
    } lane_ctrl_t;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] cmd;
        logic                        zero;
    } lane_res_t;

endpackage

`default_nettype wire

// ===== src/ptst_lane.sv =====
`default_nettype none

module ptst_lane #(
    parameter int ANGLE_WIDTH   = 20,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire ptst_pkg::lane_ctrl_t                 ctrl,
    input  wire ptst_pkg::cfg_t                       cfg,
    input  wire logic                                 subtract,
    input  wire logic signed [ptst_pkg::IN_WIDTH-1:0] angle_now,
    input  wire logic signed [ptst_pkg::IN_WIDTH-1:0] offset,
    output ptst_pkg::lane_res_t                       res
);

    localparam int TW = ptst_pkg::TARGET_WIDTH;
    localparam int IW = ptst_pkg::IN_WIDTH;
    localparam int OW = ptst_pkg::OUT_WIDTH;
    localparam int PW = ptst_pkg::GAIN_WIDTH + 1 + IW;
    localparam int HW = IW + 1;
    localparam int W  = ((TW > ANGLE_WIDTH) ? TW : ANGLE_WIDTH) + 2;

    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          adj;
    logic signed [TW-1:0]          now_ext;
    logic signed [TW-1:0]          adj_ext;
    logic signed [TW-1:0]          target;
    logic signed [HW-1:0]          cur_h;
    logic signed [HW-1:0]          mag_h;
    logic signed [HW-1:0]          step_h;
    logic signed [HW-1:0]          home_h;
    logic signed [TW-1:0]          tgt_next;
    logic signed [TW-1:0]          tgt_reg;
    logic signed [ANGLE_WIDTH-1:0] last_reg;
    logic signed [ANGLE_WIDTH-1:0] last_next;
    logic signed [W-1:0]           last_w;
    logic signed [W-1:0]           tgt_w;
    logic signed [W-1:0]           diff;
    logic signed [W-1:0]           lim;
    logic signed [W-1:0]           neg_lim;
    logic signed [W-1:0]           dclamp;
    logic signed [W-1:0]           sum;
    logic                          fits_angle;
    logic signed [ANGLE_WIDTH-1:0] slew_val;
    logic signed [W-1:0]           chosen_w;
    logic                          fits_out;

    // tracking target: measured angle adjusted by gain times offset, floor shift
    assign prod    = $signed({1'b0, cfg.gain}) * offset;
    assign adj     = prod >>> FRACTION_BITS;
    assign now_ext = TW'(angle_now);
    assign adj_ext = TW'(adj);
    assign target  = subtract ? (now_ext - adj_ext) : (now_ext + adj_ext);

    // lost target: step the measured angle toward zero, snap inside one step
    assign cur_h  = HW'(angle_now);
    assign mag_h  = angle_now[IW-1] ? -cur_h : cur_h;
    assign step_h = $signed({{(HW - ptst_pkg::STEP_WIDTH){1'b0}}, cfg.recovery_step});
    always_comb begin
        if (mag_h > step_h) begin
            home_h = angle_now[IW-1] ? (cur_h + step_h) : (cur_h - step_h);
        end else begin
            home_h = '0;
        end
    end

    assign tgt_next = ctrl.seen_in ? target : TW'(home_h);

    // first stage register, no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            tgt_reg <= tgt_next;
        end
    end

    // slew limit against the stored command
    assign last_w  = W'(last_reg);
    assign tgt_w   = W'(tgt_reg);
    assign diff    = tgt_w - last_w;
    assign lim     = W'({1'b0, cfg.track_step});
    assign neg_lim = -lim;
    always_comb begin
        if (diff > lim) begin
            dclamp = lim;
        end else if (diff < neg_lim) begin
            dclamp = neg_lim;
        end else begin
            dclamp = diff;
        end
    end
    assign sum = last_w + dclamp;

    // saturate to the stored command width
    assign fits_angle = (sum[W-1:ANGLE_WIDTH-1] == {(W - ANGLE_WIDTH + 1){sum[W-1]}});
    assign slew_val   = fits_angle ? sum[ANGLE_WIDTH-1:0]
                                   : {sum[W-1], {(ANGLE_WIDTH - 1){~sum[W-1]}}};

    // stored command moves only on a tracking tick leaving the first stage
    assign last_next = (ctrl.advance && ctrl.seen_s1) ? slew_val : last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else begin
            last_reg <= last_next;
        end
    end

    // saturate the chosen command to the output width
    assign chosen_w = ctrl.seen_s1 ? W'(slew_val) : tgt_w;
    assign fits_out = (chosen_w[W-1:OW-1] == {(W - OW + 1){chosen_w[W-1]}});
    assign res.cmd  = fits_out ? chosen_w[OW-1:0]
                               : {chosen_w[W-1], {(OW - 1){~chosen_w[W-1]}}};
    assign res.zero = (tgt_reg == '0);

endmodule

`default_nettype wire

// ===== src/ptst_merge.sv =====
`default_nettype none

module ptst_merge (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ptst_pkg::lane_ctrl_t ctrl,
    input  wire ptst_pkg::lane_res_t  yaw_res,
    input  wire ptst_pkg::lane_res_t  pitch_res,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [39:0]               m_tdata,
    output logic                      m_tuser
);

    localparam int OW = ptst_pkg::OUT_WIDTH;

    logic                 valid_reg;
    logic                 valid_next;
    logic signed [OW-1:0] yaw_reg;
    logic signed [OW-1:0] pitch_reg;
    logic                 rec_reg;
    logic                 rec_next;
    logic                 pos_reg;

    // recovering is set on a recovery result unless both axes land on zero
    assign rec_next = !ctrl.seen_s1 && !(yaw_res.zero && pitch_res.zero);

    always_comb begin
        if (ctrl.advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            yaw_reg   <= yaw_res.cmd;
            pitch_reg <= pitch_res.cmd;
            rec_reg   <= rec_next;
            pos_reg   <= ctrl.seen_s1;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, rec_reg, pitch_reg, yaw_reg};
    assign m_tuser  = pos_reg;

endmodule

`default_nettype wire

// ===== src/pan_tilt_slew_tracker.sv =====
// an accepted request passes through the first stage register and then the output register
// throughput: one request per cycle unless stalled; the loop is the slew clamp against the stored command
// each axis runs in its own lane, the merge stage forms the recovering flag
// reset (aresetn low, synchronous): pipeline empties and stored commands clear,
// configuration returns to gain 154, track step 51, recovery step 256
`default_nettype none

module pan_tilt_slew_tracker #(
    parameter int ANGLE_WIDTH   = 20,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [71:0]                           s_tdata,  // yaw_now, pitch_now, offset_x, offset_y
    input  wire logic                                  s_tuser,  // target_seen
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [39:0]                                m_tdata,  // yaw_cmd, pitch_cmd, recovering, zero pad
    output logic                                       m_tuser,  // position_mode
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ptst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [ptst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int IW = ptst_pkg::IN_WIDTH;

    ptst_pkg::cfg_t       cfg_reg;
    ptst_pkg::cfg_t       cfg_next;
    ptst_pkg::lane_ctrl_t ctrl;
    ptst_pkg::lane_res_t  yaw_res;
    ptst_pkg::lane_res_t  pitch_res;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 seen_reg;
    logic                 accept;
    logic                 advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (ptst_pkg::cfg_index_t'(cfg_index))
                ptst_pkg::CFG_TRACK_GAIN:    cfg_next.gain          = cfg_data[7:0];
                ptst_pkg::CFG_TRACK_STEP:    cfg_next.track_step    = cfg_data;
                ptst_pkg::CFG_RECOVERY_STEP: cfg_next.recovery_step = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain          <= 8'd154;
            cfg_reg.track_step    <= 16'd51;
            cfg_reg.recovery_step <= 16'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // stage handshake: first stage drains into the output register
    assign advance  = s1_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seen_reg <= s_tuser;
        end
    end

    assign ctrl.load    = accept;
    assign ctrl.advance = advance;
    assign ctrl.seen_in = s_tuser;
    assign ctrl.seen_s1 = seen_reg;

    // pan lane: aims at measured minus gain times offset
    ptst_lane #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_yaw_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .subtract  (1'b1),
        .angle_now ($signed(s_tdata[IW-1:0])),
        .offset    ($signed(s_tdata[3*IW-1:2*IW])),
        .res       (yaw_res)
    );

    // tilt lane: aims at measured plus gain times offset
    ptst_lane #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pitch_lane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .subtract  (1'b0),
        .angle_now ($signed(s_tdata[2*IW-1:IW])),
        .offset    ($signed(s_tdata[4*IW-1:3*IW])),
        .res       (pitch_res)
    );

    // merge stage and output register
    ptst_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .yaw_res   (yaw_res),
        .pitch_res (pitch_res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // a tracking result never reports recovery
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[36])
        else $error("recovering set on a tracking result");

    // recovery only while some axis is still away from zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> (m_tdata[17:0] != 18'd0 || m_tdata[35:18] != 18'd0))
        else $error("recovering set with both axes at zero");

    // a request held in the first stage is not dropped while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_tvalid && !m_tready |=> s1_valid_reg)
        else $error("first stage request lost under stall");

    // a request leaving the first stage shows up at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced request missing at output");

endmodule

`default_nettype wire
